FILE: sv/crc16fc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 frame checker package
// Frame layout constants, verdict codes, register indexes and the CRC step.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

  localparam int MAX_PAYLOAD  = 256;
  localparam int HEADER_BYTES = 8;
  localparam int CRC_BYTES    = 2;
  localparam int INDEX_W      = 17;
  localparam int CFG_IDX_W    = 2;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef logic [INDEX_W-1:0] index_t;

  localparam index_t INDEX_TOP = '1;

  // header byte positions
  localparam index_t POS_MAGIC0  = index_t'(0);
  localparam index_t POS_MAGIC1  = index_t'(1);
  localparam index_t POS_VERSION = index_t'(2);
  localparam index_t POS_TYPE    = index_t'(3);
  localparam index_t POS_SEQ_LO  = index_t'(4);
  localparam index_t POS_SEQ_HI  = index_t'(5);
  localparam index_t POS_LEN_LO  = index_t'(6);
  localparam index_t POS_LEN_HI  = index_t'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_FIRST  = 2'd0,
    CFG_MAGIC_SECOND = 2'd1,
    CFG_VERSION      = 2'd2,
    CFG_CRC_INIT     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_LENGTH    = 3'd5,
    ST_CRC       = 3'd6
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  frame_type;
    logic [15:0] frame_seq;
    logic [15:0] payload_length;
  } result_t;

  // MSB-first CRC-16 over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/crc16fc_if.sv
// ----------------------------------------------------------------------------
// CRC-16 frame checker channels
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface crc16fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface crc16fc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [15:0] frame_seq;
  logic [15:0] payload_length;

  modport source (output valid, output result_kind, output payload_byte, output status,
                  output frame_type, output frame_seq, output payload_length,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte, input status,
                  input frame_type, input frame_seq, input payload_length,
                  output ready);
endinterface

interface crc16fc_cfg_if import crc16fc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/crc16_frame_checker_core.sv
// ----------------------------------------------------------------------------
// CRC-16 frame checker core
// Checks length-prefixed frames byte by byte, forwards payload bytes and
// gives one verdict per frame on its last byte.
// ----------------------------------------------------------------------------
//  channel | role | transaction
//  frame   | sink | one received byte with last-byte mark
//  result  | src  | forwarded payload byte or end-of-frame verdict
//  cfg     | sink | register write (index, data), always ready
//
// One byte is taken per cycle while the frame channel is ready; its result is registered
// in the output buffer. The per-byte CRC, header checks and verdict select are
// combinational between the frame state and the result register.
// A two-entry output buffer lets a byte in while one result waits; frame
// stalls only when both entries are full. Synchronous reset clears the frame
// state and loads the register defaults.
// ----------------------------------------------------------------------------
module crc16_frame_checker_core import crc16fc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  crc16fc_in_if.sink     frame,
  crc16fc_out_if.source  result,
  crc16fc_cfg_if.sink    cfg
);

  // configuration registers
  logic [7:0]  magic_first;
  logic [7:0]  magic_second;
  logic [7:0]  protocol_version;
  logic [15:0] crc_init;

  // frame state
  index_t      byte_index;
  logic [15:0] running_crc;
  logic [7:0]  held_type;
  logic [15:0] held_sequence;
  logic [15:0] held_length;
  logic [15:0] received_crc;
  logic        magic_bad;
  logic        version_bad;

  index_t      byte_index_next;
  logic [15:0] running_crc_next;
  logic [7:0]  held_type_next;
  logic [15:0] held_sequence_next;
  logic [15:0] held_length_next;
  logic [15:0] received_crc_next;
  logic        magic_bad_next;
  logic        version_bad_next;

  // output buffer
  logic        out_valid;
  result_t     out_res;
  logic        skid_valid;
  result_t     skid_res;

  logic        accept;
  logic        pop;
  logic        push;
  logic        has_result;
  logic        in_body;
  index_t      body_end;
  logic [15:0] crc_base;
  status_t     verdict;
  result_t     new_res;

  assign cfg.ready   = 1'b1;
  assign frame.ready = !skid_valid;
  assign accept      = frame.valid && frame.ready;
  assign pop         = out_valid && result.ready;
  assign push        = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first      <= '0;
      magic_second     <= '0;
      protocol_version <= '0;
      crc_init         <= 16'hFFFF;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_MAGIC_FIRST:  magic_first      <= cfg.data[7:0];
        CFG_MAGIC_SECOND: magic_second     <= cfg.data[7:0];
        CFG_VERSION:      protocol_version <= cfg.data[7:0];
        CFG_CRC_INIT:     crc_init         <= cfg.data;
      endcase
    end
  end

  // header capture and checks
  always_comb begin
    held_type_next     = held_type;
    held_sequence_next = held_sequence;
    held_length_next   = held_length;
    magic_bad_next     = magic_bad;
    version_bad_next   = version_bad;
    case (byte_index)
      POS_MAGIC0:  if (frame.data_byte != magic_first) magic_bad_next = 1'b1;
      POS_MAGIC1:  if (frame.data_byte != magic_second) magic_bad_next = 1'b1;
      POS_VERSION: if (frame.data_byte != protocol_version) version_bad_next = 1'b1;
      POS_TYPE:    held_type_next = frame.data_byte;
      POS_SEQ_LO:  held_sequence_next = {held_sequence[15:8], frame.data_byte};
      POS_SEQ_HI:  held_sequence_next = {frame.data_byte, held_sequence[7:0]};
      POS_LEN_LO:  held_length_next = {held_length[15:8], frame.data_byte};
      POS_LEN_HI:  held_length_next = {frame.data_byte, held_length[7:0]};
      default:     ;
    endcase
  end

  // CRC, counter and verdict
  always_comb begin
    crc_base          = (byte_index == '0) ? crc_init : running_crc;
    body_end          = index_t'({1'b0, held_length_next}) + index_t'(HEADER_BYTES);
    in_body           = byte_index < body_end;
    running_crc_next  = (byte_index < index_t'(HEADER_BYTES) || in_body)
                        ? crc16_byte(crc_base, frame.data_byte) : crc_base;
    received_crc_next = {frame.data_byte, received_crc[15:8]};
    byte_index_next   = (byte_index == INDEX_TOP) ? byte_index : byte_index + index_t'(1);

    if (byte_index < index_t'(HEADER_BYTES + CRC_BYTES - 1)) begin
      verdict = ST_SHORT;
    end else if (magic_bad_next) begin
      verdict = ST_MAGIC;
    end else if (version_bad_next) begin
      verdict = ST_VERSION;
    end else if ({1'b0, held_length_next} > 17'(MAX_PAYLOAD)) begin
      verdict = ST_TOO_LARGE;
    end else if (byte_index != body_end + index_t'(CRC_BYTES - 1)) begin
      verdict = ST_LENGTH;
    end else if (running_crc_next != received_crc_next) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end

    has_result = frame.end_of_frame || (byte_index >= index_t'(HEADER_BYTES) && in_body);

    if (frame.end_of_frame) begin
      new_res.result_kind    = KIND_VERDICT;
      new_res.payload_byte   = '0;
      new_res.status         = verdict;
      new_res.frame_type     = held_type_next;
      new_res.frame_seq      = held_sequence_next;
      new_res.payload_length = held_length_next;
    end else begin
      new_res.result_kind    = KIND_PAYLOAD;
      new_res.payload_byte   = frame.data_byte;
      new_res.status         = ST_OK;
      new_res.frame_type     = '0;
      new_res.frame_seq      = '0;
      new_res.payload_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      running_crc   <= '0;
      held_type     <= '0;
      held_sequence <= '0;
      held_length   <= '0;
      received_crc  <= '0;
      magic_bad     <= 1'b0;
      version_bad   <= 1'b0;
    end else if (accept) begin
      running_crc <= running_crc_next;
      if (frame.end_of_frame) begin
        // clear the frame state for the next frame
        byte_index    <= '0;
        held_type     <= '0;
        held_sequence <= '0;
        held_length   <= '0;
        received_crc  <= '0;
        magic_bad     <= 1'b0;
        version_bad   <= 1'b0;
      end else begin
        byte_index    <= byte_index_next;
        held_type     <= held_type_next;
        held_sequence <= held_sequence_next;
        held_length   <= held_length_next;
        received_crc  <= received_crc_next;
        magic_bad     <= magic_bad_next;
        version_bad   <= version_bad_next;
      end
    end
  end

  // two-entry output buffer: skid entry drains into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || pop) begin
      if (push) begin
        out_res <= new_res;
      end
    end else if (push) begin
      skid_res <= new_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.result_kind    = out_res.result_kind;
  assign result.payload_byte   = out_res.payload_byte;
  assign result.status         = out_res.status;
  assign result.frame_type     = out_res.frame_type;
  assign result.frame_seq      = out_res.frame_seq;
  assign result.payload_length = out_res.payload_length;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && frame.end_of_frame) |=> (byte_index == '0))
    else $error("byte counter not cleared after last byte");

  a_index_monotonic: assert property (@(posedge clk) disable iff (rst)
    (byte_index != '0) |=> (byte_index == '0 || byte_index >= $past(byte_index)))
    else $error("byte counter moved backwards within a frame");

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.result_kind) |-> (result.payload_byte == '0))
    else $error("verdict carries a payload byte");
`endif

endmodule
